/* hdl/pixelize_block_average_unit_defines.svh */
// Assertion macros shared by the pixelize block average unit.
`ifndef PIXELIZE_BLOCK_AVERAGE_UNIT_DEFINES_SVH
`define PIXELIZE_BLOCK_AVERAGE_UNIT_DEFINES_SVH
`ifndef SYNTH
`define PBA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PBA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PBA_ASSERT(lbl, prop, msg)
`define PBA_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* hdl/pba_pkg.sv */
// Package with the constants, types and helpers of the pixelize block average unit.
package pba_pkg;

    localparam int SUM_W          = 20;
    localparam int BYTE_W         = 8;
    localparam int NUM_IN         = 4;
    localparam int ROW_LIMIT      = 4096;
    localparam int ROW_W          = 12;
    localparam int IDX_W          = 12;
    localparam int IMG_REG_W      = 13;
    localparam int TILE_REG_W     = 7;
    localparam int APB_ADDR_W     = 4;
    localparam int APB_DATA_W     = 32;
    localparam int AVG_MAX        = 255;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_CHANNELS   = 4;
    localparam int DEF_MAX_TILE   = 64;

    localparam logic [IMG_REG_W-1:0]  RST_IMAGE_WIDTH  = IMG_REG_W'(640);
    localparam logic [IMG_REG_W-1:0]  RST_IMAGE_HEIGHT = IMG_REG_W'(480);
    localparam logic [TILE_REG_W-1:0] RST_TILE_WIDTH   = TILE_REG_W'(10);
    localparam logic [TILE_REG_W-1:0] RST_TILE_HEIGHT  = TILE_REG_W'(10);

    typedef enum logic [1:0]
    {
        REG_IMAGE_WIDTH,
        REG_IMAGE_HEIGHT,
        REG_TILE_WIDTH,
        REG_TILE_HEIGHT
    } reg_idx_t;

    typedef struct packed
    {
        logic [IMG_REG_W-1:0]  image_width;
        logic [IMG_REG_W-1:0]  image_height;
        logic [TILE_REG_W-1:0] tile_width;
        logic [TILE_REG_W-1:0] tile_height;
    } pba_cfg_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_ACC,
        ST_DIV
    } pba_state_t;

    // Largest counter value for a size register: zero acts as one, large values clip.
    function automatic logic [31:0] bound_m1(logic [31:0] v, logic [31:0] hi);
        logic [31:0] r;
        if (v == 32'd0)
            r = 32'd0;
        else if (v > hi)
            r = hi - 32'd1;
        else
            r = v - 32'd1;
        return r;
    endfunction

endpackage

/* hdl/pba_if.sv */
// Request channel interfaces for pixels in and tile averages out.
interface pba_pix_if;
    import pba_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] byte0;
    logic [BYTE_W-1:0] byte1;
    logic [BYTE_W-1:0] byte2;
    logic [BYTE_W-1:0] byte3;
    modport source (output valid, byte0, byte1, byte2, byte3, input ready);
    modport sink (input valid, byte0, byte1, byte2, byte3, output ready);
endinterface

interface pba_tile_if;
    import pba_pkg::*;
    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  tile_col;
    logic [IDX_W-1:0]  tile_row;
    logic [BYTE_W-1:0] avg0;
    logic [BYTE_W-1:0] avg1;
    logic [BYTE_W-1:0] avg2;
    logic [BYTE_W-1:0] avg3;
    logic              last_tile;
    modport source (output valid, tile_col, tile_row, avg0, avg1, avg2, avg3, last_tile,
                     input ready);
    modport sink (input valid, tile_col, tile_row, avg0, avg1, avg2, avg3, last_tile,
                   output ready);
endinterface

/* hdl/pba_cfg_regs.sv */
// APB configuration registers for image and tile size.
module pba_cfg_regs
    import pba_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output pba_cfg_t              cfg
);

    pba_cfg_t cfg_reg;
    reg_idx_t idx;

    assign idx    = reg_idx_t'(paddr[3:2]);
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width  <= RST_IMAGE_WIDTH;
            cfg_reg.image_height <= RST_IMAGE_HEIGHT;
            cfg_reg.tile_width   <= RST_TILE_WIDTH;
            cfg_reg.tile_height  <= RST_TILE_HEIGHT;
        end
        else if (psel && penable && pwrite)
        begin
            case (idx)
                REG_IMAGE_WIDTH:  cfg_reg.image_width  <= pwdata[IMG_REG_W-1:0];
                REG_IMAGE_HEIGHT: cfg_reg.image_height <= pwdata[IMG_REG_W-1:0];
                REG_TILE_WIDTH:   cfg_reg.tile_width   <= pwdata[TILE_REG_W-1:0];
                REG_TILE_HEIGHT:  cfg_reg.tile_height  <= pwdata[TILE_REG_W-1:0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(cfg_reg.image_width);
            REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(cfg_reg.image_height);
            REG_TILE_WIDTH:   prdata = APB_DATA_W'(cfg_reg.tile_width);
            REG_TILE_HEIGHT:  prdata = APB_DATA_W'(cfg_reg.tile_height);
            default:          prdata = '0;
        endcase
    end

endmodule

/* hdl/pba_sum_mem.sv */
// Column sum memory, one row per tile column, registered read.
module pba_sum_mem
    import pba_pkg::*;
#(
    parameter int DEPTH  = DEF_MAX_WIDTH,
    parameter int DATA_W = DEF_CHANNELS * SUM_W
)
(
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

endmodule

/* hdl/pba_divider.sv */
// Restoring divider, one quotient bit per cycle for all lanes, result saturated to a byte.
module pba_divider
    import pba_pkg::*;
#(
    parameter int LANES = DEF_CHANNELS,
    parameter int DIV_W = 14
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [SUM_W-1:0]  dividend [LANES],
    input  logic [DIV_W-1:0]  divisor,
    output logic              done,
    output logic [BYTE_W-1:0] quot [LANES]
);

    localparam int STEP_W = $clog2(SUM_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [DIV_W-1:0]  div_reg;
    logic [SUM_W-1:0]  num_reg [LANES];
    logic [DIV_W-1:0]  rem_reg [LANES];
    logic [SUM_W-1:0]  num_next [LANES];
    logic [DIV_W-1:0]  rem_next [LANES];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        step_next = step_reg;
        if (start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            step_next = '0;
        end
        else if (busy_reg)
        begin
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(SUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        logic [DIV_W:0] trial;
        for (int l = 0; l < LANES; l++)
        begin
            trial = {rem_reg[l], num_reg[l][SUM_W-1]};
            if (trial >= {1'b0, div_reg})
            begin
                rem_next[l] = DIV_W'(trial - {1'b0, div_reg});
                num_next[l] = {num_reg[l][SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[l] = trial[DIV_W-1:0];
                num_next[l] = {num_reg[l][SUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            div_reg <= divisor;
            for (int l = 0; l < LANES; l++)
            begin
                num_reg[l] <= dividend[l];
                rem_reg[l] <= '0;
            end
        end
        else if (busy_reg)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                num_reg[l] <= num_next[l];
                rem_reg[l] <= rem_next[l];
            end
        end
    end

    assign done = done_reg;

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
            quot[l] = (num_reg[l] > SUM_W'(AVG_MAX)) ? BYTE_W'(AVG_MAX) : num_reg[l][BYTE_W-1:0];
    end

endmodule

/* hdl/pixelize_block_average_unit.sv */
// Top level of the pixelize block average unit: counters, sequencer and output register.
//
// Pixels enter on the pix channel in raster order, four bytes each; tile averages leave
// on the tile channel. Image and tile size are set over the APB port; the user sets them
// only while the block is idle, which the block itself does not enforce. Writes complete
// in the access cycle and pready is always high. Each pixel is first accepted, with its
// tile column's sums read from the sum memory, and then its bytes are added and the sums
// written back. A pixel that closes a tile then starts a division of twenty quotient bits
// per lane, and the result is loaded once the division is done and the output register is free.
// The finished result waits in an output register; the block goes on accepting pixels
// while it waits, accepts none while a division runs, and stalls further when a second
// result is ready before the first has been taken.
// Reset clears the counters and loads the default sizes (640 by 480, tiles of 10 by 10).
// The sum memory needs no clearing, as every tile's first pixel overwrites its row.
`include "pixelize_block_average_unit_defines.svh"
module pixelize_block_average_unit
    import pba_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    parameter int CHANNELS  = DEF_CHANNELS,
    parameter int MAX_TILE  = DEF_MAX_TILE
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    pba_pix_if.sink               pix,
    pba_tile_if.source            tile
);

    localparam int USED  = (CHANNELS < NUM_IN) ? CHANNELS : NUM_IN;
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int TC_W  = $clog2(MAX_TILE);
    localparam int CNT_W = 2 * (TC_W + 1);
    localparam int MEM_W = USED * SUM_W;

    pba_cfg_t cfg;

    pba_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    logic [COL_W-1:0] wm1;
    logic [ROW_W-1:0] hm1;
    logic [TC_W-1:0]  twm1;
    logic [TC_W-1:0]  thm1;

    assign wm1  = COL_W'(bound_m1(32'(cfg.image_width), 32'(MAX_WIDTH)));
    assign hm1  = ROW_W'(bound_m1(32'(cfg.image_height), 32'(ROW_LIMIT)));
    assign twm1 = TC_W'(bound_m1(32'(cfg.tile_width), 32'(MAX_TILE)));
    assign thm1 = TC_W'(bound_m1(32'(cfg.tile_height), 32'(MAX_TILE)));

    pba_state_t state_reg, state_next;

    logic [COL_W-1:0] col_pos_reg, col_pos_next;
    logic [ROW_W-1:0] row_pos_reg, row_pos_next;
    logic [TC_W-1:0]  cit_reg, cit_next;
    logic [TC_W-1:0]  rit_reg, rit_next;
    logic [COL_W-1:0] tcp_reg, tcp_next;
    logic [ROW_W-1:0] trp_reg, trp_next;

    logic              first_reg, emit_reg, last_reg;
    logic [COL_W-1:0]  addr_reg;
    logic [IDX_W-1:0]  otc_reg, otr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [BYTE_W-1:0] byte_reg [USED];
    logic [BYTE_W-1:0] pix_bytes [NUM_IN];

    logic              out_valid_reg;
    logic [IDX_W-1:0]  out_col_reg, out_row_reg;
    logic              out_last_reg;
    logic [BYTE_W-1:0] out_avg_reg [NUM_IN];

    logic              accept, line_end, frame_end, tc_end, tr_end, first_px;
    logic              in_ready, mem_rd_en, mem_wr_en, div_start, out_load;
    logic [MEM_W-1:0]  rd_data, wr_data;
    logic [SUM_W-1:0]  new_sum [USED];
    logic              div_done;
    logic [BYTE_W-1:0] quot [USED];

    assign pix_bytes[0] = pix.byte0;
    assign pix_bytes[1] = pix.byte1;
    assign pix_bytes[2] = pix.byte2;
    assign pix_bytes[3] = pix.byte3;

    assign accept    = pix.valid && in_ready;
    assign line_end  = col_pos_reg >= wm1;
    assign frame_end = row_pos_reg >= hm1;
    assign tc_end    = line_end || (cit_reg >= twm1);
    assign tr_end    = frame_end || (rit_reg >= thm1);
    assign first_px  = (cit_reg == '0) && (rit_reg == '0);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (accept)
                    state_next = ST_ACC;
            ST_ACC:
                state_next = emit_reg ? ST_DIV : ST_IDLE;
            ST_DIV:
                if (div_done && (!out_valid_reg || tile.ready))
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        mem_rd_en = 1'b0;
        mem_wr_en = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                mem_rd_en = pix.valid;
            end
            ST_ACC:
            begin
                mem_wr_en = 1'b1;
                div_start = emit_reg;
            end
            ST_DIV:
                out_load = div_done && (!out_valid_reg || tile.ready);
            default:
                in_ready = 1'b0;
        endcase
    end

    always_comb
    begin
        col_pos_next = col_pos_reg;
        row_pos_next = row_pos_reg;
        cit_next     = cit_reg;
        rit_next     = rit_reg;
        tcp_next     = tcp_reg;
        trp_next     = trp_reg;
        if (line_end)
        begin
            col_pos_next = '0;
            cit_next     = '0;
            tcp_next     = '0;
            if (frame_end)
            begin
                row_pos_next = '0;
                rit_next     = '0;
                trp_next     = '0;
            end
            else
            begin
                row_pos_next = row_pos_reg + 1'b1;
                if (tr_end)
                begin
                    rit_next = '0;
                    trp_next = trp_reg + 1'b1;
                end
                else
                    rit_next = rit_reg + 1'b1;
            end
        end
        else
        begin
            col_pos_next = col_pos_reg + 1'b1;
            if (tc_end)
            begin
                cit_next = '0;
                tcp_next = tcp_reg + 1'b1;
            end
            else
                cit_next = cit_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            col_pos_reg <= '0;
            row_pos_reg <= '0;
            cit_reg     <= '0;
            rit_reg     <= '0;
            tcp_reg     <= '0;
            trp_reg     <= '0;
            emit_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                col_pos_reg <= col_pos_next;
                row_pos_reg <= row_pos_next;
                cit_reg     <= cit_next;
                rit_reg     <= rit_next;
                tcp_reg     <= tcp_next;
                trp_reg     <= trp_next;
                emit_reg    <= tc_end && tr_end;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            first_reg <= first_px;
            last_reg  <= line_end && frame_end;
            addr_reg  <= tcp_reg;
            otc_reg   <= IDX_W'(tcp_reg);
            otr_reg   <= IDX_W'(trp_reg);
            count_reg <= (CNT_W'(cit_reg) + 1'b1) * (CNT_W'(rit_reg) + 1'b1);
            for (int c = 0; c < USED; c++)
                byte_reg[c] <= pix_bytes[c];
        end
    end

    pba_sum_mem #(.DEPTH(MAX_WIDTH), .DATA_W(MEM_W)) u_mem
    (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (tcp_reg),
        .rd_data (rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (addr_reg),
        .wr_data (wr_data)
    );

    always_comb
    begin
        logic [SUM_W:0] s;
        for (int c = 0; c < USED; c++)
        begin
            s = first_reg ? (SUM_W + 1)'(byte_reg[c])
                          : {1'b0, rd_data[c*SUM_W +: SUM_W]} + (SUM_W + 1)'(byte_reg[c]);
            new_sum[c] = s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
            wr_data[c*SUM_W +: SUM_W] = new_sum[c];
        end
    end

    pba_divider #(.LANES(USED), .DIV_W(CNT_W)) u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (new_sum),
        .divisor  (count_reg),
        .done     (div_done),
        .quot     (quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (tile.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_col_reg  <= otc_reg;
            out_row_reg  <= otr_reg;
            out_last_reg <= last_reg;
            for (int c = 0; c < NUM_IN; c++)
                out_avg_reg[c] <= (c < USED) ? quot[c % USED] : '0;
        end
    end

    assign pix.ready      = in_ready;
    assign tile.valid     = out_valid_reg;
    assign tile.tile_col  = out_col_reg;
    assign tile.tile_row  = out_row_reg;
    assign tile.avg0      = out_avg_reg[0];
    assign tile.avg1      = out_avg_reg[1];
    assign tile.avg2      = out_avg_reg[2];
    assign tile.avg3      = out_avg_reg[3];
    assign tile.last_tile = out_last_reg;

    `PBA_ASSERT(a_accept_to_acc, (pix.valid && pix.ready) |=> (state_reg == ST_ACC),
        "Accepted pixel was not followed by the accumulate cycle.")
    `PBA_ASSERT(a_emit_to_div, (state_reg == ST_ACC && emit_reg) |=> (state_reg == ST_DIV),
        "Tile end did not start the division.")
    `PBA_ASSERT(a_result_from_div, $rose(tile.valid) |-> $past(state_reg == ST_DIV && div_done),
        "Result appeared without a finished division.")
    `PBA_ASSERT_ALWAYS(a_reset_idle, $rose(rst_n) |-> (state_reg == ST_IDLE && !tile.valid),
        "Block not idle when leaving reset.")

endmodule

/* test/pixelize_block_average_unit_tb.sv */
// Self-checking testbench of the pixelize block average unit: whole frames against a tile predictor.
module pixelize_block_average_unit_tb;
    import pba_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed
    {
        logic [IDX_W-1:0]  tile_col;
        logic [IDX_W-1:0]  tile_row;
        logic [BYTE_W-1:0] avg0;
        logic [BYTE_W-1:0] avg1;
        logic [BYTE_W-1:0] avg2;
        logic [BYTE_W-1:0] avg3;
        logic              last_tile;
    } tile_avg_t;

    typedef struct packed
    {
        logic [IMG_REG_W-1:0]  img_w;
        logic [IMG_REG_W-1:0]  img_h;
        logic [TILE_REG_W-1:0] til_w;
        logic [TILE_REG_W-1:0] til_h;
        logic [3:0][7:0]       px;
        logic                  typed;
        tile_avg_t             res;
    } pixel_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    pba_pix_if  pix_ch();
    pba_tile_if tile_ch();

    pixelize_block_average_unit u_dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .pix     (pix_ch.sink),
        .tile    (tile_ch.source)
    );

    always #6 clk = ~clk;

    // Configuration and counters of the tile predictor.
    int unsigned cfg_w = 640, cfg_h = 480, cfg_tw = 10, cfg_th = 10;
    int unsigned col_pos = 0, row_pos = 0, col_in = 0, row_in = 0, tcol = 0, trow = 0;
    logic [SUM_W-1:0] band_sums [4096][4];

    tile_avg_t  tile_q[$];
    pixel_row_t table_rows[$];
    int  fails = 0;
    int  tiles_seen = 0;
    bit  hold_off = 1'b0;
    bit  gaps_on = 1'b1;
    bit  stall_on = 1'b1;

    function automatic int unsigned clip_size(int unsigned v, int unsigned hi);
        if (v == 0)
            return 1;
        return (v > hi) ? hi : v;
    endfunction

    function automatic bit tile_average(input logic [3:0][7:0] px, output tile_avg_t r);
        int unsigned w, h, tw, th, cnt, s, a;
        bit first, line_end, frame_end, col_end, row_end, done;
        logic [3:0][7:0] avgs;
        w = clip_size(cfg_w, 4096);
        h = clip_size(cfg_h, 4096);
        tw = clip_size(cfg_tw, 64);
        th = clip_size(cfg_th, 64);
        first = (col_in == 0) && (row_in == 0);
        line_end = col_pos >= w - 1;
        frame_end = row_pos >= h - 1;
        col_end = line_end || col_in >= tw - 1;
        row_end = frame_end || row_in >= th - 1;
        for (int c = 0; c < 4; c++)
        begin
            s = (first ? 0 : band_sums[tcol % 4096][c]) + px[c];
            band_sums[tcol % 4096][c] = (s > 20'hFFFFF) ? 20'hFFFFF : SUM_W'(s);
        end
        done = col_end && row_end;
        r = '0;
        if (done)
        begin
            cnt = (col_in + 1) * (row_in + 1);
            for (int c = 0; c < 4; c++)
            begin
                a = band_sums[tcol % 4096][c] / cnt;
                avgs[c] = (a > AVG_MAX) ? BYTE_W'(AVG_MAX) : BYTE_W'(a);
            end
            r.tile_col = IDX_W'(tcol);
            r.tile_row = IDX_W'(trow);
            r.avg0 = avgs[0];
            r.avg1 = avgs[1];
            r.avg2 = avgs[2];
            r.avg3 = avgs[3];
            r.last_tile = line_end && frame_end;
        end
        if (line_end)
        begin
            col_pos = 0;
            col_in = 0;
            tcol = 0;
            if (frame_end)
            begin
                row_pos = 0;
                row_in = 0;
                trow = 0;
            end
            else
            begin
                row_pos++;
                if (row_end)
                begin
                    row_in = 0;
                    trow++;
                end
                else
                    row_in++;
            end
        end
        else
        begin
            col_pos++;
            if (col_end)
            begin
                col_in = 0;
                tcol++;
            end
            else
                col_in++;
        end
        return done;
    endfunction

    task automatic reg_write(input reg_idx_t idx, input int unsigned val);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = APB_ADDR_W'(4 * int'(idx));
        pwdata = val;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_IMAGE_WIDTH:  cfg_w = val & 32'h1FFF;
            REG_IMAGE_HEIGHT: cfg_h = val & 32'h1FFF;
            REG_TILE_WIDTH:   cfg_tw = val & 32'h7F;
            default:          cfg_th = val & 32'h7F;
        endcase
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic settle();
        @(negedge clk);
        pix_ch.valid = 1'b0;
        wait (tile_q.size() == 0);
        repeat (30) @(posedge clk);
    endtask

    task automatic set_sizes(input int unsigned w, h, tw, th);
        settle();
        reg_write(REG_IMAGE_WIDTH, w);
        reg_write(REG_IMAGE_HEIGHT, h);
        reg_write(REG_TILE_WIDTH, tw);
        reg_write(REG_TILE_HEIGHT, th);
    endtask

    task automatic send_pixel(input logic [3:0][7:0] px, input bit typed, input tile_avg_t res);
        int unsigned gap;
        tile_avg_t r;
        @(negedge clk);
        pix_ch.valid = 1'b1;
        pix_ch.byte0 = px[0];
        pix_ch.byte1 = px[1];
        pix_ch.byte2 = px[2];
        pix_ch.byte3 = px[3];
        do
            @(posedge clk);
        while (!pix_ch.ready);
        if (tile_average(px, r))
            tile_q = {tile_q, (typed ? res : r)};
        gap = 0;
        if (gaps_on)
        begin
            gap = $urandom_range(0, 9);
            gap = (gap < 7) ? 0 : (gap < 9) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        end
        if (gap > 0)
        begin
            @(negedge clk);
            pix_ch.valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic send_frame(input int unsigned w, h, tw, th);
        int unsigned n;
        set_sizes(w, h, tw, th);
        n = clip_size(w & 32'h1FFF, 4096) * clip_size(h & 32'h1FFF, 4096);
        gaps_on = $urandom_range(0, 3) != 0;
        stall_on = $urandom_range(0, 3) != 0;
        for (int i = 0; i < n; i++)
            send_pixel($urandom(), 1'b0, '0);
    endtask

    task automatic add_row(input int unsigned w, h, tw, th, input logic [31:0] px,
                           input bit typed, input tile_avg_t res);
        pixel_row_t row;
        row.img_w = IMG_REG_W'(w);
        row.img_h = IMG_REG_W'(h);
        row.til_w = TILE_REG_W'(tw);
        row.til_h = TILE_REG_W'(th);
        row.px = px;
        row.typed = typed;
        row.res = res;
        table_rows = {table_rows, row};
    endtask

    // Receiver: random stalls, plus one long hold-off.
    always @(negedge clk)
        tile_ch.ready <= !hold_off && (!stall_on || $urandom_range(0, 3) != 0);

    always @(posedge clk)
    begin
        tile_avg_t e;
        if (rst_n && tile_ch.valid && tile_ch.ready)
        begin
            tiles_seen++;
            if (tile_q.size() == 0)
            begin
                $error("tile result with none expected");
                fails++;
            end
            else
            begin
                e = tile_q.pop_front();
                if (e.tile_col !== tile_ch.tile_col)
                begin
                    $error("tile_col: expected %0d, got %0d", e.tile_col, tile_ch.tile_col);
                    fails++;
                end
                if (e.tile_row !== tile_ch.tile_row)
                begin
                    $error("tile_row: expected %0d, got %0d", e.tile_row, tile_ch.tile_row);
                    fails++;
                end
                if (e.avg0 !== tile_ch.avg0)
                begin
                    $error("avg0: expected %0d, got %0d", e.avg0, tile_ch.avg0);
                    fails++;
                end
                if (e.avg1 !== tile_ch.avg1)
                begin
                    $error("avg1: expected %0d, got %0d", e.avg1, tile_ch.avg1);
                    fails++;
                end
                if (e.avg2 !== tile_ch.avg2)
                begin
                    $error("avg2: expected %0d, got %0d", e.avg2, tile_ch.avg2);
                    fails++;
                end
                if (e.avg3 !== tile_ch.avg3)
                begin
                    $error("avg3: expected %0d, got %0d", e.avg3, tile_ch.avg3);
                    fails++;
                end
                if (e.last_tile !== tile_ch.last_tile)
                begin
                    $error("last_tile: expected %0d, got %0d", e.last_tile, tile_ch.last_tile);
                    fails++;
                end
            end
        end
    end

    initial
    begin
        wait (tiles_seen >= 20);
        hold_off = 1'b1;
        repeat (400) @(negedge clk);
        hold_off = 1'b0;
    end

    initial
    begin
        #40ms;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        pixel_row_t row;
        int unsigned done_items;
        logic [IMG_REG_W-1:0] cw, ch;
        logic [TILE_REG_W-1:0] ctw, cth;
        pix_ch.valid = 1'b0;
        pix_ch.byte0 = '0;
        pix_ch.byte1 = '0;
        pix_ch.byte2 = '0;
        pix_ch.byte3 = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // A single-pixel image returns each pixel unchanged as the last tile.
        add_row(1, 1, 0, 0, 32'h00000000, 1'b1, {12'd0, 12'd0, 32'h00000000, 1'b1});
        add_row(1, 1, 0, 0, 32'hFFFFFFFF, 1'b1, {12'd0, 12'd0, 32'hFFFFFFFF, 1'b1});
        add_row(1, 1, 0, 0, 32'hF00F5AA5, 1'b1, {12'd0, 12'd0, 32'hA55A0FF0, 1'b1});
        // One-pixel tiles along a line.
        add_row(3, 1, 1, 1, 32'h04030201, 1'b1, {12'd0, 12'd0, 32'h01020304, 1'b0});
        add_row(3, 1, 1, 1, 32'hFF00FF00, 1'b1, {12'd1, 12'd0, 32'h00FF00FF, 1'b0});
        add_row(3, 1, 1, 1, 32'h80808080, 1'b1, {12'd2, 12'd0, 32'h80808080, 1'b1});
        // Oversized tile clipped to the image.
        add_row(2, 2, 127, 64, 32'hFFFFFFFF, 1'b0, '0);
        add_row(2, 2, 127, 64, 32'hFFFFFFFE, 1'b0, '0);
        add_row(2, 2, 127, 64, 32'h00000000, 1'b0, '0);
        add_row(2, 2, 127, 64, 32'h01FF7F80, 1'b0, '0);
        // Clipped tiles at the right and bottom edges, zero image width acting as one.
        for (int i = 0; i < 9; i++)
            add_row(3, 3, 2, 2, {8'(i * 29), 8'(255 - i), 8'(i * 77), 8'(i)}, 1'b0, '0);
        for (int i = 0; i < 3; i++)
            add_row(0, 3, 0, 2, {4{8'(i * 100 + 7)}}, 1'b0, '0);

        cw = '1;
        foreach (table_rows[i])
        begin
            row = table_rows[i];
            if (row.img_w != cw || row.img_h != ch || row.til_w != ctw || row.til_h != cth)
            begin
                set_sizes(row.img_w, row.img_h, row.til_w, row.til_h);
                cw = row.img_w;
                ch = row.img_h;
                ctw = row.til_w;
                cth = row.til_h;
            end
            send_pixel(row.px, row.typed, row.res);
        end

        // Tile sizes above the largest tile act as the largest tile.
        send_frame(130, 1, 100, 0);
        send_frame(65, 2, 127, 64);

        done_items = 0;
        while (done_items < 1100)
        begin
            int unsigned w, h;
            w = $urandom_range(1, 24);
            h = $urandom_range(1, 12);
            send_frame(w, h, $urandom_range(0, 9), $urandom_range(0, 9));
            done_items += w * h;
        end
        send_frame(1, 70, 0, 127);
        send_frame(66, 5, 64, 2);
        send_frame(40, 2, 10, 10);

        @(negedge clk);
        pix_ch.valid = 1'b0;
        settle();
        if (fails == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
